// File: sv/t33ks_pkg.sv
// Shared types and constants for the times-33 key shard selector.
// No dependencies; imported by every module of the block.
`default_nettype none

package t33ks_pkg;

   localparam int unsigned HASH_W  = 32;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned STEP_W  = 5;   // counts the HASH_W divide steps

   localparam logic [HASH_W-1:0]  HASH_SEED   = 32'd5381;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1;
   localparam logic [STEP_W-1:0]  LAST_STEP   = 5'd31;

   typedef logic [HASH_W-1:0] hash_type;

   // front -> queue push
   typedef struct packed {
      logic     valid;
      hash_type hash;
   } hash_push_type;

   // queue -> back head of queue
   typedef struct packed {
      logic     valid;
      hash_type hash;
   } hash_head_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_HOLD   = 3'b100
   } back_state_type;

endpackage

`default_nettype wire

// File: sv/times33_key_shard_select_top.sv
// Top level of the times-33 key shard selector: front, queue, back, shard count register.
// Depends on t33ks_pkg, t33ks_front, t33ks_queue and t33ks_back.
//
// Usage
//   req_*  : one key byte per transaction. tdata = key_byte, tuser = byte_present,
//            tlast = last_byte. A transaction with tuser low and tlast high closes
//            the key without adding a byte (empty key gives the hash of 5381).
//   rsp_*  : one transaction per key: tdata = shard_index, tuser = count_error.
//   csr_*  : write of shard_count; always ready. Write only while the block is idle.
// Throughput: key bytes go in at one per cycle. Each closed key costs the back end
//   a load, 32 one-bit remainder steps and a hand-off to the output register,
//   set by the bit-serial remainder unit; only the load and hand-off when the count is zero.
//   The front keeps hashing the next key meanwhile; req_tready drops only when the
//   hash queue is full.
// Reset: accumulator returns to 5381, shard_count to 1, queue and output empty.
// Stall: a held result stays in the output register; the back end can finish one
//   more remainder behind it, then the queue fills and req_tready falls.
`default_nettype none

module times33_key_shard_select_top
   import t33ks_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // key byte channel
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] key_byte
   input  wire logic                req_tuser,   // [0] byte_present
   input  wire logic                req_tlast,   // last_byte
   // shard result channel
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [15:0]         rsp_tdata,   // [15:0] shard_index
   output      logic                rsp_tuser,   // [0] count_error
   // shard count register write
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [15:0]         csr_data     // [15:0] shard_count
);

   localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH+1);

   logic [COUNT_W-1:0] shard_count_ff;
   hash_push_type      push;
   hash_head_type      head;
   logic               queue_full;
   logic               pop;
   logic [FILL_W-1:0]  queue_fill;
   hash_type           hash_state;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shard_count_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         shard_count_ff <= csr_data;
      end
   end

   t33ks_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .hash_state (hash_state)
   );

   t33ks_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop),
      .fill  (queue_fill)
   );

   t33ks_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .shard_count (shard_count_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // a closed key always restarts the hash from the seed
   a_seed_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (hash_state == HASH_SEED))
      else $error("accumulator not restored after last byte");

   // an error result never carries an index
   a_error_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("count error with non-zero shard index");

   // queue never overfills, and a full queue holds off the key stream
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (queue_fill == FILL_W'(QUEUE_DEPTH)) |-> !req_tready)
      else $error("key stream ready while hash queue full");

endmodule

`default_nettype wire

// File: sv/t33ks_front.sv
// Front end: accepts key byte transactions and runs the times-33 hash.
// Depends on t33ks_pkg; pushes finished hashes into t33ks_queue.
`default_nettype none

module t33ks_front
   import t33ks_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [BYTE_W-1:0]   req_tdata,
   input  wire logic                req_tuser,
   input  wire logic                req_tlast,
   input  wire logic                queue_full,
   output      hash_push_type       push,
   output      hash_type            hash_state
);

   hash_type acc_ff, acc_in;
   hash_type sum;
   logic     accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // acc * 33 + sign-extended byte when byte_present is set, else acc; wrapping at 32 bits
   always_comb begin
      sum = acc_ff;
      if (req_tuser) begin
         sum = (acc_ff << 5) + acc_ff + {{(HASH_W-BYTE_W){req_tdata[BYTE_W-1]}}, req_tdata};
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = req_tlast ? HASH_SEED : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= HASH_SEED;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign push.valid = accept && req_tlast;
   assign push.hash  = sum;
   assign hash_state = acc_ff;

endmodule

`default_nettype wire

// File: sv/t33ks_queue.sv
// Short FIFO of finished hashes between front and back end.
// Depends on t33ks_pkg.
`default_nettype none

module t33ks_queue
   import t33ks_pkg::*;
#(
   parameter int unsigned DEPTH = 2   // 2 .. 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire hash_push_type               push,
   output      logic                        full,
   output      hash_head_type               head,
   input  wire logic                        pop,
   output      logic [$clog2(DEPTH+1)-1:0]  fill
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   hash_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.hash;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.hash  = mem_ff[rd_ptr_ff];
   assign fill       = count_ff;

endmodule

`default_nettype wire

// File: sv/t33ks_back.sv
// Back end: bit-serial remainder of |hash| by the shard count, plus output register.
// Depends on t33ks_pkg; takes hashes from t33ks_queue.
`default_nettype none

module t33ks_back
   import t33ks_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hash_head_type       head,
   output      logic                pop,
   input  wire logic [COUNT_W-1:0]  shard_count,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [COUNT_W-1:0]  rsp_tdata,
   output      logic                rsp_tuser
);

   back_state_type       state_ff, state_in;
   hash_type             dividend_ff, dividend_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic                 err_ff, err_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_data_ff;
   logic                 rsp_err_ff;

   logic [COUNT_W:0]     trial;
   logic [COUNT_W:0]     trial_sub;
   logic [COUNT_W-1:0]   rem_next;
   hash_type             magnitude;
   logic                 slot_free;
   logic                 load_out;

   assign magnitude = head.hash[HASH_W-1] ? (HASH_W'(0) - head.hash) : head.hash;

   // one restoring step: remainder stays below the divisor, so 17 bits suffice
   assign trial     = {rem_ff, dividend_ff[HASH_W-1]};
   assign trial_sub = trial - {1'b0, shard_count};
   assign rem_next  = (trial >= {1'b0, shard_count}) ? trial_sub[COUNT_W-1:0]
                                                     : trial[COUNT_W-1:0];

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign load_out  = (state_ff == ST_HOLD) && slot_free;
   assign pop       = (state_ff == ST_IDLE) && head.valid;

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      err_in      = err_ff;
      step_in     = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               dividend_in = magnitude;
               rem_in      = '0;
               step_in     = LAST_STEP;
               err_in      = (shard_count == '0);
               state_in    = (shard_count == '0) ? ST_HOLD : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in      = rem_next;
            dividend_in = dividend_ff << 1;
            step_in     = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      err_ff      <= err_in;
      step_ff     <= step_in;
      if (load_out) begin
         rsp_data_ff <= err_ff ? '0 : rem_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for times33_key_shard_select_top: djb2 key hash and shard choice.
// Depends on t33ks_pkg and the block's RTL; predicts each shard result and checks it.

module tb_top
   import t33ks_pkg::*;
();

   localparam int GAP_MAX       = 13;
   localparam int SETTLE_CYCLES = 40;     // back-end settle margin after the last result
   localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
   localparam int QUIET_LIMIT   = 2000;   // cycles with no transaction before giving up
   localparam int RANDOM_ITEMS  = 1000;
   localparam int PHASES        = 10;

   typedef struct packed {
      logic [COUNT_W-1:0] shard_index;
      logic               count_error;
   } shard_result_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block ports; all inputs known from time zero
   // ---------------------------------------------------------------------
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [COUNT_W-1:0] rsp_tdata;
   logic               rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data   = '0;

   always #1 clock = ~clock;

   times33_key_shard_select_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------
   // Predictor state: running hash, shard count copy, results still owed
   // ---------------------------------------------------------------------
   hash_type           model_hash        = HASH_SEED;
   logic [COUNT_W-1:0] model_shard_count = COUNT_RESET;
   shard_result_type   shards_due[$];
   int                 failures          = 0;
   int                 key_items_sent    = 0;   // idle items not counted
   bit                 gaps_on           = 1'b1;
   int                 rsp_hold_request  = 0;   // set by a test, taken by the sink

   // Shard of a finished hash: magnitude of the signed hash, then remainder.
   // Taking the magnitude as unsigned keeps -2^31 intact.
   function automatic shard_result_type shard_of_hash(input hash_type h,
                                                      input logic [COUNT_W-1:0] count);
      shard_result_type r;
      hash_type         magnitude;
      r = '0;
      if (count == '0) begin
         r.count_error = 1'b1;
      end else begin
         magnitude     = h[HASH_W-1] ? hash_type'(0) - h : h;
         r.shard_index = COUNT_W'(magnitude % hash_type'(count));
      end
      return r;
   endfunction

   function automatic int draw_gap();
      return gaps_on ? $urandom_range(0, GAP_MAX) : 0;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one key byte transaction, prediction at the accepting edge
   // ---------------------------------------------------------------------
   task automatic send_key_byte(input logic [BYTE_W-1:0] key_byte,
                                input logic present, input logic last);
      int               gap;
      shard_result_type owed;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key_byte;
      req_tuser  <= present;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      // times 33 plus the byte as a signed char, wrapping at 32 bits
      if (present)
         model_hash = (model_hash << 5) + model_hash
                      + {{(HASH_W - BYTE_W){key_byte[BYTE_W-1]}}, key_byte};
      if (last) begin
         owed = shard_of_hash(model_hash, model_shard_count);
         shards_due.insert(shards_due.size(), owed);
         model_hash = HASH_SEED;
      end
      if (present || last)
         key_items_sent++;
   endtask

   // Sender stops, waits for every owed result, then lets the back end settle
   task automatic wait_shards_drained();
      req_tvalid <= 1'b0;
      while (shards_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only with the block idle and at a key boundary
   task automatic write_shard_count(input logic [COUNT_W-1:0] count);
      wait_shards_drained();
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      model_shard_count = count;
   endtask

   // Seven bytes whose hash is exactly target: write target - 5381*33^7 in
   // balanced base 33 (digits -16..16), least significant digit last.
   task automatic send_key_for_hash(input hash_type target);
      hash_type          offset;
      hash_type          diff;
      longint            rest;
      longint            digit;
      logic [BYTE_W-1:0] key_bytes [7];
      offset = HASH_SEED;
      repeat (7) offset = offset * 33;
      diff = target - offset;
      rest = $signed(diff);
      for (int i = 6; i >= 0; i--) begin
         digit = rest % 33;
         if (digit > 16)
            digit -= 33;
         else if (digit < -16)
            digit += 33;
         key_bytes[i] = digit[BYTE_W-1:0];
         rest = (rest - digit) / 33;
      end
      for (int i = 0; i < 7; i++)
         send_key_byte(key_bytes[i], 1'b1, i == 6);
   endtask

   // Mostly well-formed keys; now and then a fully random item breaks in
   task automatic send_random_key();
      int key_len;
      bit close_on_byte;
      key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      close_on_byte = (key_len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < key_len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_key_byte(BYTE_W'($urandom), 1'($urandom), 1'($urandom));
         send_key_byte(BYTE_W'($urandom), 1'b1, close_on_byte && (i == key_len - 1));
      end
      if (!close_on_byte)
         send_key_byte(BYTE_W'($urandom), 1'b0, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset count of one: every shard is 0
   task automatic test_reset_count();
      send_key_byte(8'h00, 1'b0, 1'b1);
      send_key_byte(8'hFF, 1'b1, 1'b1);
   endtask

   // Byte extremes, sign of the byte, idle item inside a key, closing
   // transaction without a byte
   task automatic test_directed_keys();
      write_shard_count(16'hFFFF);
      send_key_byte(8'h00, 1'b0, 1'b1);
      send_key_byte(8'h00, 1'b1, 1'b0);
      send_key_byte(8'h5A, 1'b0, 1'b0);
      send_key_byte(8'hFF, 1'b1, 1'b1);
      send_key_byte(8'h7F, 1'b1, 1'b0);
      send_key_byte(8'h80, 1'b1, 1'b1);
      send_key_byte(8'hA5, 1'b1, 1'b0);
      send_key_byte(8'h00, 1'b0, 1'b1);
   endtask

   // Most negative and most positive signed hash
   task automatic test_extreme_hashes();
      send_key_for_hash(32'h8000_0000);
      send_key_for_hash(32'h7FFF_FFFF);
   endtask

   // Count of zero flags an error; the hash must still restart at 5381
   task automatic test_zero_count();
      write_shard_count(16'h0000);
      send_key_byte(8'h80, 1'b1, 1'b1);
      send_key_byte(8'h00, 1'b0, 1'b1);
      write_shard_count(16'hFFFF);
      send_key_byte(8'h00, 1'b0, 1'b1);
   endtask

   // Receiver holds off while short keys keep coming, so the queue fills and
   // req_tready falls; then the sender waits for everything to drain
   task automatic test_output_stall();
      write_shard_count(16'd7);
      gaps_on = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      for (int i = 0; i < 16; i++)
         send_key_byte(BYTE_W'($urandom), 1'b1, 1'b1);
      wait_shards_drained();
      gaps_on = 1'b1;
   endtask

   // Random keys over several shard counts, extremes included
   task automatic test_random_keys();
      logic [COUNT_W-1:0] counts [PHASES];
      int                 goal;
      counts = '{16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd3, 16'd33, 16'hFFFE, 16'h8000,
                 COUNT_W'($urandom_range(1, 65535)), COUNT_W'($urandom_range(1, 255))};
      for (int p = 0; p < PHASES; p++) begin
         write_shard_count(counts[p]);
         gaps_on = ($urandom_range(0, 3) != 0);   // some phases run flat out
         goal = key_items_sent + RANDOM_ITEMS / PHASES;
         while (key_items_sent < goal)
            send_random_key();
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Result sink: random stalls per transaction, long hold on request
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int               stall_left;
      shard_result_type due;
      stall_left = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tready && rsp_tvalid === 1'b1) begin
            if (shards_due.size() == 0) begin
               failures++;
               $display("%0t: result with none expected, actual index %0d error %0b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               due = shards_due.pop_front();
               if (rsp_tdata !== due.shard_index) begin
                  failures++;
                  $display("%0t: shard_index mismatch, expected %0d, actual %0d",
                           $time, due.shard_index, rsp_tdata);
               end
               if (rsp_tuser !== due.count_error) begin
                  failures++;
                  $display("%0t: count_error mismatch, expected %0b, actual %0b",
                           $time, due.count_error, rsp_tuser);
               end
            end
            stall_left = draw_gap();
         end
         if (rsp_hold_request > 0) begin
            stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long without any transaction ends the run
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_count();
      test_directed_keys();
      test_extreme_hashes();
      test_zero_count();
      test_output_stall();
      test_random_keys();
      wait_shards_drained();
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
